// ===== hdl/adcavg_pkg.sv =====
// Shared types and constants for the ADC average, smoothing and digit split block.
`default_nettype none

package adcavg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SAMPLES_PER_READING = 2'd0;
  localparam logic [1:0] REG_SMOOTH_GAIN         = 2'd1;
  localparam logic [1:0] REG_SCALE_GAIN          = 2'd2;

  // Register reset values.
  localparam logic [7:0] RESET_SAMPLES_PER_READING = 8'd255;
  localparam logic [7:0] RESET_SMOOTH_GAIN         = 8'd200;
  localparam logic [7:0] RESET_SCALE_GAIN          = 8'd200;

  // Decimal split constants.
  localparam logic [7:0] TWO_HUNDRED = 8'd200;
  localparam logic [7:0] ONE_HUNDRED = 8'd100;
  localparam logic [7:0] TEN         = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_UPDATE,
    ST_SCALE,
    ST_HUNDREDS,
    ST_TENS,
    ST_FINISH
  } adcavg_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic diff;
    logic update;
    logic scale;
    logic hundreds;
    logic tens;
    logic load;
  } adcavg_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic reading_due;
    logic tens_done;
    logic out_free;
  } adcavg_sts_t;

endpackage

`default_nettype wire

// ===== hdl/adc_average_smooth_to_digits.sv =====
// Top level of the ADC average, smoothing and decimal digit split block.
//
// Samples arrive on the sample channel (sample_valid, sample_stall); a beat is
// taken at a clock edge with valid high and stall low. Each sample is added to
// a running sum. When samples_per_reading samples have been summed, the sum
// divided by 256 pulls the smoothed level toward it, the smoothed level is
// scaled, and one result beat (hundreds, tens, ones, smoothed_level) is
// produced on the result channel (result_valid, result_stall).
// A sample that does not complete a reading leaves the block ready for the next
// sample. A sample that completes a reading runs through two 8x8 multiplies in
// sequence, a hundreds compare, and a loop that subtracts ten per tens digit.
// The result sits in an output register, so the next samples are taken while
// it waits; only a further reading waits for that register to be taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is samples_per_reading, 1 smooth_gain, 2 scale_gain,
// and other indexes are ignored. Synchronous reset restores 255, 200 and 200,
// clears the sum, count and smoothed level, and drops result_valid.
`default_nettype none

module adc_average_smooth_to_digits
  import adcavg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       sample_valid,
  output logic            sample_stall,
  input  wire logic [7:0] sample,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [1:0]      hundreds,
  output logic [3:0]      tens,
  output logic [3:0]      ones,
  output logic [7:0]      smoothed_level
);

  adcavg_cmd_t cmd;
  adcavg_sts_t sts;

  assign cfg_ready = 1'b1;

  adcavg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  adcavg_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .cmd            (cmd),
    .sts            (sts),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .hundreds       (hundreds),
    .tens           (tens),
    .ones           (ones),
    .smoothed_level (smoothed_level)
  );

endmodule

`default_nettype wire

// ===== hdl/adcavg_ctrl.sv =====
// Controller state machine that sequences one reading through the datapath.
`default_nettype none

module adcavg_ctrl
  import adcavg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire adcavg_sts_t sts,
  output adcavg_cmd_t      cmd
);

  adcavg_state_t state;
  adcavg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          if (sts.reading_due) begin
            state_next = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_HUNDREDS;
      end
      ST_HUNDREDS: begin
        cmd.hundreds = 1'b1;
        state_next   = ST_TENS;
      end
      ST_TENS: begin
        if (sts.tens_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.tens = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/adcavg_datapath.sv =====
// Datapath: configuration registers, sample accumulator, smoothing, scaling and digit split.
`default_nettype none

module adcavg_datapath
  import adcavg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic [7:0]  sample,
  input  wire adcavg_cmd_t cmd,
  output adcavg_sts_t      sts,
  input  wire logic        result_stall,
  output logic             result_valid,
  output logic [1:0]       hundreds,
  output logic [3:0]       tens,
  output logic [3:0]       ones,
  output logic [7:0]       smoothed_level
);

  logic [7:0]  samples_per_reading;
  logic [7:0]  smooth_gain;
  logic [7:0]  scale_gain;
  logic [15:0] sample_sum;
  logic [7:0]  sample_count;
  logic [7:0]  smoothed;

  logic [15:0] sum_next;
  logic [7:0]  count_next;
  logic [7:0]  average;
  logic        step_down;
  logic [15:0] product;
  logic [7:0]  scaled;
  logic [7:0]  remainder;
  logic [1:0]  hund_digit;
  logic [3:0]  tens_digit;
  logic [7:0]  difference;

  assign sum_next   = sample_sum + {8'd0, sample};
  assign count_next = sample_count + 8'd1;
  assign scaled     = product[15:8];
  assign difference = (smoothed > average) ? (smoothed - average) : (average - smoothed);

  // A wrapped count or a count at or above the limit closes the reading,
  // which also makes a limit of zero behave like one.
  assign sts.reading_due = (count_next == 8'd0) || (count_next >= samples_per_reading);
  assign sts.tens_done   = (remainder < TEN);
  assign sts.out_free    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_reading <= RESET_SAMPLES_PER_READING;
      smooth_gain         <= RESET_SMOOTH_GAIN;
      scale_gain          <= RESET_SCALE_GAIN;
      sample_sum          <= '0;
      sample_count        <= '0;
      smoothed            <= '0;
      result_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SAMPLES_PER_READING: samples_per_reading <= cfg_data;
          REG_SMOOTH_GAIN:         smooth_gain         <= cfg_data;
          REG_SCALE_GAIN:          scale_gain          <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        if (sts.reading_due) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= count_next;
        end
      end
      // The step never exceeds the difference, so no wrap can occur here.
      if (cmd.update) begin
        if (step_down) begin
          smoothed <= smoothed - product[15:8];
        end else begin
          smoothed <= smoothed + product[15:8];
        end
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      average <= sum_next[15:8];
    end
    if (cmd.diff) begin
      step_down <= (smoothed > average);
      product   <= {8'd0, difference} * {8'd0, smooth_gain};
    end
    if (cmd.scale) begin
      product <= {8'd0, smoothed} * {8'd0, scale_gain};
    end
    if (cmd.hundreds) begin
      tens_digit <= '0;
      if (scaled >= TWO_HUNDRED) begin
        hund_digit <= 2'd2;
        remainder  <= scaled - TWO_HUNDRED;
      end else if (scaled >= ONE_HUNDRED) begin
        hund_digit <= 2'd1;
        remainder  <= scaled - ONE_HUNDRED;
      end else begin
        hund_digit <= 2'd0;
        remainder  <= scaled;
      end
    end
    if (cmd.tens) begin
      remainder  <= remainder - TEN;
      tens_digit <= tens_digit + 4'd1;
    end
    if (cmd.load) begin
      hundreds       <= hund_digit;
      tens           <= tens_digit;
      ones           <= remainder[3:0];
      smoothed_level <= smoothed;
    end
  end

endmodule

`default_nettype wire
